// ===== rtl/rgbw_pkg.sv =====
package rgbw_pkg;

  // Grid limits and field widths.
  localparam int unsigned MAX_GRID_SIDE = 4096;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned PITCH_W       = 31;
  localparam int unsigned CNT_W         = 13;
  localparam int unsigned TOL_W         = 16;
  localparam int unsigned IDX_W         = 12;
  localparam int unsigned NODE_W        = 24;
  localparam int unsigned FRAC_W        = 17;
  localparam int unsigned MODE_W        = 2;

  // Internal datapath widths.
  localparam int unsigned OFS_W  = COORD_W + 1;       // offset from origin
  localparam int unsigned DD_W   = OFS_W + 1;         // offset plus tolerance
  localparam int unsigned DREM_W = OFS_W;             // locate divider remainder
  localparam int unsigned M_W    = IDX_W + PITCH_W;   // (n-1) * pitch
  localparam int unsigned E_W    = M_W + 2;           // offset from the last node
  localparam int unsigned R_W    = E_W + 1;           // residual within a cell
  localparam int unsigned FREM_W = PITCH_W + 17;      // fraction divider remainder
  localparam int unsigned PROD_W = 2 * FRAC_W;

  // Pipeline depth of one axis: two setup stages, one stage per quotient bit of
  // the cell search, one decision stage and one stage per fraction bit.
  localparam int unsigned DIV_STEPS   = IDX_W;
  localparam int unsigned FRAC_STEPS  = FRAC_W;
  localparam int unsigned AXIS_STAGES = 2 + DIV_STEPS + 1 + FRAC_STEPS;

  localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(65536);

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_X_ORIGIN  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_Y_ORIGIN  = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_X_SPACING = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_Y_SPACING = CFG_ADDR_W'(3);
  localparam logic [CFG_ADDR_W-1:0] REG_COLUMNS   = CFG_ADDR_W'(4);
  localparam logic [CFG_ADDR_W-1:0] REG_ROWS      = CFG_ADDR_W'(5);
  localparam logic [CFG_ADDR_W-1:0] REG_Y_REV     = CFG_ADDR_W'(6);
  localparam logic [CFG_ADDR_W-1:0] REG_TOL       = CFG_ADDR_W'(7);

  // Interpolation modes.
  localparam logic [MODE_W-1:0] MODE_COLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LIN_X = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LIN_Y = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BILIN = 2'd3;

  // Stream layouts.
  localparam int unsigned IN_TDATA_W  = 2 * COORD_W;
  localparam int unsigned OT_COL      = 0;
  localparam int unsigned OT_ROW      = OT_COL + IDX_W;
  localparam int unsigned OT_NODE     = OT_ROW + IDX_W;
  localparam int unsigned OT_WB       = OT_NODE + NODE_W;
  localparam int unsigned OT_WC       = OT_WB + FRAC_W;
  localparam int unsigned OT_WR       = OT_WC + FRAC_W;
  localparam int unsigned OT_WD       = OT_WR + FRAC_W;
  localparam int unsigned OT_END      = OT_WD + FRAC_W;
  localparam int unsigned OUT_TDATA_W = ((OT_END + 7) / 8) * 8;
  localparam int unsigned TU_MODE     = 0;
  localparam int unsigned TU_OUT      = MODE_W;
  localparam int unsigned OUT_TUSER_W = MODE_W + 1;

  // Per-axis answer handed from the axis pipeline to the combining stages.
  typedef struct packed {
    logic              located;
    logic              colocated;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  near_idx;
    logic [FRAC_W-1:0] frac;
  } rgbw_axis_res_t;

endpackage

// ===== rtl/regular_grid_bilinear_weights_core.sv =====
// Bilinear weight generator for a regular 2-D grid. Each input beat carries one
// projected point (Q24.8); each output beat carries the base node of the cell
// that holds it, its flat node index, the interpolation mode, four Q1.16
// weights and a flag that marks the nearest-node fallback for points outside
// the grid. The block takes one point per clock unless the pipeline is full
// and the output stalled. One stage forms the offsets from the origin, each
// axis then runs a 32-stage pipeline (two setup stages, a 12-stage restoring
// divider that finds the cell, one decision stage and a 17-stage divider for
// the fraction), and two final stages form the weights and the node index.
// Every stage has a valid bit; a stage moves whenever it or any stage after it
// is empty or the consumer is ready, so an output stall only backs up the
// input once the pipeline is full, and nothing is lost or repeated. The
// configuration registers may be written only while no point is in flight;
// quantities derived from them are kept in registers that follow each write.
module regular_grid_bilinear_weights_core import rgbw_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input point stream.
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // target_x[31:0], target_y[63:32]
  // Result stream.
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // cell_column[11:0], cell_row[23:12],
                                                  // node_index[47:24], weight_base[64:48],
                                                  // weight_next_column[81:65],
                                                  // weight_next_row[98:82],
                                                  // weight_diagonal[115:99], zeros[119:116]
  output logic [OUT_TUSER_W-1:0]  m_axis_tuser,   // mode[1:0], outside_domain[2]
  // Configuration writes.
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [COORD_W-1:0]      cfg_data_i
);

  localparam int unsigned NST = AXIS_STAGES + 3;
  localparam int unsigned C1  = AXIS_STAGES + 1;
  localparam int unsigned C2  = AXIS_STAGES + 2;

  // Configuration registers. Writes are always taken; unknown indexes are dropped.
  logic [COORD_W-1:0] x_origin_q, y_origin_q;
  logic [PITCH_W-1:0] x_spacing_q, y_spacing_q;
  logic [CNT_W-1:0]   columns_q, rows_q;
  logic               y_rev_q;
  logic [TOL_W-1:0]   tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q  <= '0;
      y_origin_q  <= '0;
      x_spacing_q <= PITCH_W'(256);
      y_spacing_q <= PITCH_W'(256);
      columns_q   <= CNT_W'(2);
      rows_q      <= CNT_W'(2);
      y_rev_q     <= 1'b0;
      tol_q       <= TOL_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_X_ORIGIN:  x_origin_q  <= cfg_data_i;
        REG_Y_ORIGIN:  y_origin_q  <= cfg_data_i;
        REG_X_SPACING: x_spacing_q <= cfg_data_i[PITCH_W-1:0];
        REG_Y_SPACING: y_spacing_q <= cfg_data_i[PITCH_W-1:0];
        REG_COLUMNS:   columns_q   <= cfg_data_i[CNT_W-1:0];
        REG_ROWS:      rows_q      <= cfg_data_i[CNT_W-1:0];
        REG_Y_REV:     y_rev_q     <= cfg_data_i[0];
        REG_TOL:       tol_q       <= cfg_data_i[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Valid bits and stage enables. Stage k loads when some stage at or after it
  // is empty, or whenever the consumer is ready for an output beat.
  logic [NST-1:0] v_q, v_d;
  logic [NST-1:0] stage_en;

  always_comb begin
    for (int k = 0; k < NST; k++) begin
      stage_en[k] = m_axis_tready | ~&(v_q | ((NST'(1) << k) - NST'(1)));
    end
    v_d[0] = stage_en[0] ? s_axis_tvalid : v_q[0];
    for (int k = 1; k < NST; k++) begin
      v_d[k] = stage_en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = stage_en[0];
  assign m_axis_tvalid = v_q[C2];

  // Stage 0: offsets from the origin. With a reversed y axis the offset is
  // mirrored so that both axes follow the same rising-index rule.
  logic signed [OFS_W-1:0] dx_q, dy_q;
  logic signed [OFS_W-1:0] tx_s, ty_s, xo_s, yo_s;

  always_comb begin
    tx_s = OFS_W'($signed(s_axis_tdata[COORD_W-1:0]));
    ty_s = OFS_W'($signed(s_axis_tdata[2*COORD_W-1:COORD_W]));
    xo_s = OFS_W'($signed(x_origin_q));
    yo_s = OFS_W'($signed(y_origin_q));
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      dx_q <= tx_s - xo_s;
      dy_q <= y_rev_q ? (yo_s - ty_s) : (ty_s - yo_s);
    end
  end

  // Per-axis cell search and fraction.
  rgbw_axis_res_t  res_x, res_y;
  logic [CNT_W-1:0] cols_eff;
  logic [CNT_W-1:0] rows_eff;

  rgbw_axis u_axis_x (
    .clk_i     (clk_i),
    .en_i      (stage_en[AXIS_STAGES:1]),
    .ofs_i     (dx_q),
    .spacing_i (x_spacing_q),
    .count_i   (columns_q),
    .tol_i     (tol_q),
    .count_o   (cols_eff),
    .res_o     (res_x)
  );

  rgbw_axis u_axis_y (
    .clk_i     (clk_i),
    .en_i      (stage_en[AXIS_STAGES:1]),
    .ofs_i     (dy_q),
    .spacing_i (y_spacing_q),
    .count_i   (rows_q),
    .tol_i     (tol_q),
    .count_o   (rows_eff),
    .res_o     (res_y)
  );

  // Combine stage 1: choose the node, the mode and start the two products.
  // When either axis has no cell, both axes fall back to their nearest node.
  logic                    outside_d, cx, cy;
  logic [IDX_W-1:0]        i_d, j_d;
  logic [MODE_W-1:0]       mode_d;
  logic                    c1_out_q;
  logic [MODE_W-1:0]       c1_mode_q;
  logic [IDX_W-1:0]        c1_i_q, c1_j_q;
  logic [FRAC_W-1:0]       c1_ax_q, c1_ay_q;
  logic [PROD_W-1:0]       c1_prod_q;
  logic [IDX_W+CNT_W-1:0]  c1_nprod_q;

  always_comb begin
    outside_d = !res_x.located || !res_y.located;
    cx        = outside_d || res_x.colocated;
    cy        = outside_d || res_y.colocated;
    i_d       = outside_d ? res_x.near_idx : res_x.idx;
    j_d       = outside_d ? res_y.near_idx : res_y.idx;
    unique case ({cy, cx})
      2'b11:   mode_d = MODE_COLOC;
      2'b10:   mode_d = MODE_LIN_X;
      2'b01:   mode_d = MODE_LIN_Y;
      default: mode_d = MODE_BILIN;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[C1]) begin
      c1_out_q   <= outside_d;
      c1_mode_q  <= mode_d;
      c1_i_q     <= i_d;
      c1_j_q     <= j_d;
      c1_ax_q    <= res_x.frac;
      c1_ay_q    <= res_y.frac;
      c1_prod_q  <= PROD_W'(res_x.frac) * PROD_W'(res_y.frac);
      c1_nprod_q <= (IDX_W+CNT_W)'(i_d) * (IDX_W+CNT_W)'(rows_eff);
    end
  end

  // Combine stage 2 (output register): weights by mode and the flat index.
  // The column count only bounds the x search; the flat index uses rows.
  logic [PROD_W:0]     wd_sum;
  logic [FRAC_W-1:0]   wd_r;
  logic [FRAC_W-1:0]   wb_d, wc_d, wr_d, wd_d;
  logic [FRAC_W-1:0]   wb_q, wc_q, wr_q, wd_q;
  logic [IDX_W-1:0]    col_q, row_q;
  logic [NODE_W-1:0]   node_q;
  logic [MODE_W-1:0]   mode_q;
  logic                out_q;
  logic                unused_cols;

  assign unused_cols = ^cols_eff;

  always_comb begin
    wd_sum = (PROD_W+1)'(c1_prod_q) + (PROD_W+1)'(32768);
    wd_r   = wd_sum[FRAC_W+15:16];
    wb_d   = ONE_Q16;
    wc_d   = '0;
    wr_d   = '0;
    wd_d   = '0;
    unique case (c1_mode_q)
      MODE_COLOC: begin
      end
      MODE_LIN_X: begin
        wb_d = ONE_Q16 - c1_ax_q;
        wc_d = c1_ax_q;
      end
      MODE_LIN_Y: begin
        wb_d = ONE_Q16 - c1_ay_q;
        wr_d = c1_ay_q;
      end
      MODE_BILIN: begin
        wd_d = wd_r;
        wc_d = c1_ax_q - wd_r;
        wr_d = c1_ay_q - wd_r;
        wb_d = ONE_Q16 - c1_ax_q - c1_ay_q + wd_r;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[C2]) begin
      col_q  <= c1_i_q;
      row_q  <= c1_j_q;
      node_q <= NODE_W'(c1_nprod_q) + NODE_W'(c1_j_q);
      mode_q <= c1_mode_q;
      out_q  <= c1_out_q ^ (unused_cols & 1'b0);
      wb_q   <= wb_d;
      wc_q   <= wc_d;
      wr_q   <= wr_d;
      wd_q   <= wd_d;
    end
  end

  assign m_axis_tdata = {(OUT_TDATA_W-OT_END)'(0), wd_q, wr_q, wc_q, wb_q, node_q, row_q, col_q};
  assign m_axis_tuser = {out_q, mode_q};

endmodule

// ===== rtl/rgbw_axis.sv =====
module rgbw_axis import rgbw_pkg::*; (
  input  logic                      clk_i,
  input  logic [AXIS_STAGES-1:0]    en_i,
  input  logic signed [OFS_W-1:0]   ofs_i,
  input  logic [PITCH_W-1:0]        spacing_i,
  input  logic [CNT_W-1:0]          count_i,
  input  logic [TOL_W-1:0]          tol_i,
  output logic [CNT_W-1:0]          count_o,
  output rgbw_axis_res_t            res_o
);

  typedef struct packed {
    logic              neg;
    logic              clamp;
    logic              e_col;
    logic              d_near;
    logic [E_W-1:0]    e;
    logic [DREM_W-1:0] rem;
    logic [IDX_W-1:0]  q;
  } div_t;

  typedef struct packed {
    logic              located;
    logic              colocated;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  near_idx;
    logic [FREM_W-1:0] rem;
    logic [FRAC_W-1:0] q;
  } frac_t;

  // Values derived from the registers, refreshed every cycle.
  logic [PITCH_W-1:0]      p_eff;
  logic [CNT_W-1:0]        n_eff;
  logic [PITCH_W-1:0]      cfg_p_q;
  logic [CNT_W-1:0]        cfg_n_q;
  logic [M_W-1:0]          cfg_m_q;
  logic signed [R_W-1:0]   cfg_pmt_q;
  logic [IDX_W-1:0]        nm1;
  logic [IDX_W-1:0]        nm2;

  always_comb begin
    p_eff = (spacing_i == '0) ? PITCH_W'(1) : spacing_i;
    if (count_i < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (count_i > CNT_W'(MAX_GRID_SIDE)) begin
      n_eff = CNT_W'(MAX_GRID_SIDE);
    end else begin
      n_eff = count_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cfg_p_q   <= p_eff;
    cfg_n_q   <= n_eff;
    cfg_m_q   <= M_W'(n_eff - CNT_W'(1)) * M_W'(p_eff);
    cfg_pmt_q <= R_W'(p_eff) - R_W'(tol_i);
  end

  assign nm1     = IDX_W'(cfg_n_q - CNT_W'(1));
  assign nm2     = IDX_W'(cfg_n_q - CNT_W'(2));
  assign count_o = cfg_n_q;

  // Stage 1: offset shifted by the tolerance, and offset from the last node.
  logic signed [OFS_W-1:0] a1_d_q;
  logic signed [DD_W-1:0]  a1_dd_q;
  logic signed [E_W-1:0]   a1_e_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a1_d_q  <= ofs_i;
      a1_dd_q <= DD_W'(ofs_i) + DD_W'(tol_i) - DD_W'(1);
      a1_e_q  <= E_W'(ofs_i) - E_W'(cfg_m_q);
    end
  end

  // Stage 2: range checks and divider setup.
  div_t                  dv_q [DIV_STEPS+1];
  div_t                  a2_d;
  logic [E_W-1:0]        abs_e;
  logic [E_W-1:0]        abs_d;
  logic signed [E_W-1:0] d_ext;

  always_comb begin
    d_ext       = E_W'(a1_d_q);
    abs_e       = (a1_e_q < 0) ? E_W'(-a1_e_q) : E_W'(a1_e_q);
    abs_d       = (d_ext < 0) ? E_W'(-d_ext) : E_W'(d_ext);
    a2_d.neg    = a1_dd_q[DD_W-1];
    a2_d.clamp  = !a1_dd_q[DD_W-1] && (M_W'(a1_dd_q[DD_W-2:0]) >= cfg_m_q);
    a2_d.e_col  = abs_e < E_W'(tol_i);
    a2_d.d_near = abs_d < abs_e;
    a2_d.e      = a1_e_q;
    a2_d.rem    = a1_dd_q[DREM_W-1:0];
    a2_d.q      = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      dv_q[0] <= a2_d;
    end
  end

  // Cell search: one quotient bit per stage, most significant first.
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    div_t           nx;
    logic [M_W-1:0] shp;
    logic           ge;

    always_comb begin
      shp = M_W'(cfg_p_q) << (DIV_STEPS - 1 - s);
      ge  = M_W'(dv_q[s].rem) >= shp;
      nx  = dv_q[s];
      if (ge) begin
        nx.rem = DREM_W'(M_W'(dv_q[s].rem) - shp);
      end
      nx.q[DIV_STEPS-1-s] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[2+s]) begin
        dv_q[s+1] <= nx;
      end
    end
  end

  // Decision stage: residual in the candidate cell and the axis verdict.
  div_t                  dv;
  frac_t                 fr_q [FRAC_STEPS+1];
  frac_t                 dc_d;
  logic signed [R_W-1:0] tol_s;
  logic signed [R_W-1:0] p_s;
  logic signed [R_W-1:0] r_s;
  logic [IDX_W-1:0]      ic;
  logic                  col_l;
  logic                  in_l;
  logic                  up;

  always_comb begin
    dv    = dv_q[DIV_STEPS];
    tol_s = R_W'(tol_i);
    p_s   = R_W'(cfg_p_q);
    if (dv.clamp) begin
      r_s = R_W'($signed(dv.e)) + p_s;
      ic  = nm2;
    end else begin
      r_s = R_W'(dv.rem) - tol_s + R_W'(1);
      ic  = dv.q;
    end
    col_l = (r_s > -tol_s) && (r_s < tol_s);
    in_l  = (r_s > tol_s) && (r_s < cfg_pmt_q);
    up    = (r_s <<< 1) > p_s;

    if (dv.e_col) begin
      dc_d.located   = 1'b1;
      dc_d.colocated = 1'b1;
      dc_d.idx       = nm1;
    end else begin
      dc_d.located   = !dv.neg && (col_l || in_l);
      dc_d.colocated = col_l;
      dc_d.idx       = ic;
    end

    if (dc_d.located) begin
      dc_d.near_idx = dc_d.colocated ? dc_d.idx : dc_d.idx + IDX_W'(up);
    end else begin
      dc_d.near_idx = dv.d_near ? '0 : nm1;
    end

    // Only meaningful when the residual lies strictly inside the cell.
    dc_d.rem = FREM_W'({r_s[PITCH_W-1:0], 16'h0000}) + FREM_W'(cfg_p_q >> 1);
    dc_d.q   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2+DIV_STEPS]) begin
      fr_q[0] <= dc_d;
    end
  end

  // Rounded fraction residual * 65536 / pitch, one bit per stage.
  for (genvar s = 0; s < FRAC_STEPS; s++) begin : g_frac
    frac_t             nx;
    logic [FREM_W-1:0] shp;
    logic              ge;

    always_comb begin
      shp = FREM_W'(cfg_p_q) << (FRAC_STEPS - 1 - s);
      ge  = fr_q[s].rem >= shp;
      nx  = fr_q[s];
      if (ge) begin
        nx.rem = fr_q[s].rem - shp;
      end
      nx.q[FRAC_STEPS-1-s] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[3+DIV_STEPS+s]) begin
        fr_q[s+1] <= nx;
      end
    end
  end

  always_comb begin
    res_o.located   = fr_q[FRAC_STEPS].located;
    res_o.colocated = fr_q[FRAC_STEPS].colocated;
    res_o.idx       = fr_q[FRAC_STEPS].idx;
    res_o.near_idx  = fr_q[FRAC_STEPS].near_idx;
    res_o.frac      = fr_q[FRAC_STEPS].q;
  end

endmodule

// ===== rtl/rgbw_checker.sv =====
module rgbw_checker import rgbw_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  logic [FRAC_W-1:0] wb, wc, wr, wd;
  logic [FRAC_W+1:0] wsum;
  logic [MODE_W-1:0] mode;
  logic              outside;

  assign wb      = m_axis_tdata[OT_WB +: FRAC_W];
  assign wc      = m_axis_tdata[OT_WC +: FRAC_W];
  assign wr      = m_axis_tdata[OT_WR +: FRAC_W];
  assign wd      = m_axis_tdata[OT_WD +: FRAC_W];
  assign wsum    = (FRAC_W+2)'(wb) + (FRAC_W+2)'(wc) + (FRAC_W+2)'(wr) + (FRAC_W+2)'(wd);
  assign mode    = m_axis_tuser[TU_MODE +: MODE_W];
  assign outside = m_axis_tuser[TU_OUT];

  // A stalled result beat stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // The weights in use always add up to one.
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> wsum == (FRAC_W+2)'(65536))
    else $error("weights do not sum to one");

  // The nearest-node fallback always reports a colocated result.
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && outside |-> mode == MODE_COLOC)
    else $error("outside point not colocated");

  // A colocated result puts the whole weight on the base node.
  a_coloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mode == MODE_COLOC |-> wb == ONE_Q16 && wc == '0 && wr == '0
      && wd == '0)
    else $error("colocated weights wrong");

endmodule

bind regular_grid_bilinear_weights_core rgbw_checker u_rgbw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rgbw_pkg::*;

  // Index past the register file; a write there must be ignored.
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = CFG_ADDR_W'(9);
  localparam int unsigned DRAIN_CYCLES = 45;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned LONG_HOLD    = 300;

  typedef struct {
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
    logic [NODE_W-1:0] node;
    logic [MODE_W-1:0] mode;
    logic [FRAC_W-1:0] wb, wc, wr, wd;
    logic              outside;
  } weights_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [COORD_W-1:0] cfg_data_i;

  regular_grid_bilinear_weights_core DUT (.*);

  // Mirror of the grid registers, raw as written.
  longint x_org, y_org, x_pitch_raw, y_pitch_raw, cols_raw, rows_raw, y_rev, tol_raw;

  logic [IN_TDATA_W-1:0] pending_points[$];
  weights_t expected_weights[$];
  int errors;
  int stall_pct, gap_max;
  bit hold_req, hold_seen;
  int hold_cnt, burst_left, gap_left, idle_cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic add_point(logic [IN_TDATA_W-1:0] pt);
    pending_points.insert(pending_points.size(), pt);
  endtask

  function automatic longint grid_count(longint raw);
    if (raw < 2) return 2;
    if (raw > MAX_GRID_SIDE) return MAX_GRID_SIDE;
    return raw;
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Cell search on one axis; later matches win, the last node is checked alone.
  function automatic longint find_cell(longint d, longint p, longint n, longint tol,
                                       output bit on_node);
    longint idx, r;
    idx = -1;
    on_node = 1'b0;
    for (longint i = 0; i < n - 1; i++) begin
      r = d - i * p;
      if (labs(r) < tol) begin
        idx = i;
        on_node = 1'b1;
      end
      if (r > tol && r < p - tol) begin
        idx = i;
        on_node = 1'b0;
      end
    end
    if (labs(d - (n - 1) * p) < tol) begin
      idx = n - 1;
      on_node = 1'b1;
    end
    return idx;
  endfunction

  function automatic longint nearest_node(longint d, longint p, longint n, longint idx,
                                          bit on_node);
    if (idx >= 0) begin
      if (!on_node && labs(d - (idx + 1) * p) < labs(d - idx * p)) return idx + 1;
      return idx;
    end
    return labs(d) < labs(d - (n - 1) * p) ? 0 : n - 1;
  endfunction

  function automatic longint cell_fraction(longint d, longint p, longint idx);
    longint r;
    r = d - idx * p;
    if (r < 0) r = 0;
    if (r > p) r = p;
    return (r * 65536 + p / 2) / p;
  endfunction

  function automatic weights_t compute_weights(logic [IN_TDATA_W-1:0] pt);
    weights_t w;
    longint nx, ny, px, py, dx, dy, ty, i, j, ax, ay, wd;
    bit cx, cy;
    nx = grid_count(cols_raw);
    ny = grid_count(rows_raw);
    px = x_pitch_raw == 0 ? 1 : x_pitch_raw;
    py = y_pitch_raw == 0 ? 1 : y_pitch_raw;
    dx = longint'($signed(pt[31:0])) - x_org;
    ty = longint'($signed(pt[63:32]));
    dy = y_rev != 0 ? y_org - ty : ty - y_org;
    i = find_cell(dx, px, nx, tol_raw, cx);
    j = find_cell(dy, py, ny, tol_raw, cy);
    w.outside = 1'b0;
    w.wb = '0; w.wc = '0; w.wr = '0; w.wd = '0;
    if (i < 0 || j < 0) begin
      i = nearest_node(dx, px, nx, i, cx);
      j = nearest_node(dy, py, ny, j, cy);
      cx = 1'b1;
      cy = 1'b1;
      w.outside = 1'b1;
    end
    if (cx && cy) begin
      w.mode = MODE_COLOC;
      w.wb = ONE_Q16;
    end else if (cy) begin
      ax = cell_fraction(dx, px, i);
      w.mode = MODE_LIN_X;
      w.wb = FRAC_W'(65536 - ax);
      w.wc = FRAC_W'(ax);
    end else if (cx) begin
      ay = cell_fraction(dy, py, j);
      w.mode = MODE_LIN_Y;
      w.wb = FRAC_W'(65536 - ay);
      w.wr = FRAC_W'(ay);
    end else begin
      ax = cell_fraction(dx, px, i);
      ay = cell_fraction(dy, py, j);
      wd = (ax * ay + 32768) >>> 16;
      w.mode = MODE_BILIN;
      w.wd = FRAC_W'(wd);
      w.wc = FRAC_W'(ax - wd);
      w.wr = FRAC_W'(ay - wd);
      w.wb = FRAC_W'(65536 - ax - ay + wd);
    end
    w.col = IDX_W'(i);
    w.row = IDX_W'(j);
    w.node = NODE_W'(i * ny + j);
    return w;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  // Point driver: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_weights.insert(expected_weights.size(), compute_weights(s_axis_tdata));
      if (s_axis_tvalid && !s_axis_tready) begin
        // Hold the beat until the block takes it.
      end else if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_points.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_points.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= gap_max == 0 ? 0 : $urandom_range(0, gap_max);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stall pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    weights_t w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt  <= 0;
      hold_seen <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_weights.size() == 0) begin
          report_mismatch("result beats", 1, 0);
        end else begin
          w = expected_weights.pop_front();
          if (m_axis_tdata[OT_COL +: IDX_W] !== w.col)
            report_mismatch("cell_column", m_axis_tdata[OT_COL +: IDX_W], w.col);
          if (m_axis_tdata[OT_ROW +: IDX_W] !== w.row)
            report_mismatch("cell_row", m_axis_tdata[OT_ROW +: IDX_W], w.row);
          if (m_axis_tdata[OT_NODE +: NODE_W] !== w.node)
            report_mismatch("node_index", m_axis_tdata[OT_NODE +: NODE_W], w.node);
          if (m_axis_tuser[TU_MODE +: MODE_W] !== w.mode)
            report_mismatch("mode", m_axis_tuser[TU_MODE +: MODE_W], w.mode);
          if (m_axis_tdata[OT_WB +: FRAC_W] !== w.wb)
            report_mismatch("weight_base", m_axis_tdata[OT_WB +: FRAC_W], w.wb);
          if (m_axis_tdata[OT_WC +: FRAC_W] !== w.wc)
            report_mismatch("weight_next_column", m_axis_tdata[OT_WC +: FRAC_W], w.wc);
          if (m_axis_tdata[OT_WR +: FRAC_W] !== w.wr)
            report_mismatch("weight_next_row", m_axis_tdata[OT_WR +: FRAC_W], w.wr);
          if (m_axis_tdata[OT_WD +: FRAC_W] !== w.wd)
            report_mismatch("weight_diagonal", m_axis_tdata[OT_WD +: FRAC_W], w.wd);
          if (m_axis_tuser[TU_OUT] !== w.outside)
            report_mismatch("outside_domain", m_axis_tuser[TU_OUT], w.outside);
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_cnt  <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("** regular_grid_bilinear_weights_core: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [COORD_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (addr)
      REG_X_ORIGIN:  x_org = longint'($signed(data));
      REG_Y_ORIGIN:  y_org = longint'($signed(data));
      REG_X_SPACING: x_pitch_raw = data[30:0];
      REG_Y_SPACING: y_pitch_raw = data[30:0];
      REG_COLUMNS:   cols_raw = data[12:0];
      REG_ROWS:      rows_raw = data[12:0];
      REG_Y_REV:     y_rev = data[0];
      REG_TOL:       tol_raw = data[15:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_grid(longint xo, longint yo, longint xp, longint yp,
                          longint nc, longint nr, longint rev, longint tol);
    write_reg(REG_X_ORIGIN, COORD_W'(xo));
    write_reg(REG_Y_ORIGIN, COORD_W'(yo));
    write_reg(REG_X_SPACING, COORD_W'(xp));
    write_reg(REG_Y_SPACING, COORD_W'(yp));
    write_reg(REG_COLUMNS, COORD_W'(nc));
    write_reg(REG_ROWS, COORD_W'(nr));
    write_reg(REG_Y_REV, COORD_W'(rev));
    write_reg(REG_TOL, COORD_W'(tol));
    // Wait for the derived quantities to settle after the last write.
    repeat (2) @(posedge clk_i);
  endtask

  // A coordinate on a node, at or near the tolerance, in a cell, or at random.
  function automatic logic [31:0] grid_coord(longint org, longint raw_p, longint raw_n,
                                             longint rev);
    longint p, n, d;
    p = raw_p == 0 ? 1 : raw_p;
    n = grid_count(raw_n);
    if ($urandom_range(0, 5) == 0) return $urandom;
    d = longint'($urandom_range(0, 32'(n - 1))) * p;
    case ($urandom_range(0, 5))
      0: ;
      1: d = d + tol_raw;
      2: d = d - tol_raw;
      3: d = d + longint'($urandom_range(0, 32'(2 * tol_raw + 2))) - tol_raw - 1;
      default: d = d + longint'($urandom_range(0, 32'(p - 1)));
    endcase
    return rev != 0 ? 32'(org - d) : 32'(org + d);
  endfunction

  task automatic run_points(int count);
    for (int k = 0; k < count; k++)
      add_point({grid_coord(y_org, y_pitch_raw, rows_raw, y_rev),
                 grid_coord(x_org, x_pitch_raw, cols_raw, 0)});
  endtask

  // Wait until every point is sent and every result is back, then let the pipe drain.
  task automatic settle;
    while (pending_points.size() > 0 || s_axis_tvalid || expected_weights.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    errors = 0;
    stall_pct = 0;
    gap_max = 0;
    hold_req = 1'b0;
    idle_cycles = 0;
    cfg_valid_i = 1'b0;
    cfg_addr_i = '0;
    cfg_data_i = '0;
    x_org = 0; y_org = 0; x_pitch_raw = 256; y_pitch_raw = 256;
    cols_raw = 2; rows_raw = 2; y_rev = 0; tol_raw = 1;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points on the reset grid: 2 x 2 nodes, pitch 1.0, tolerance 1/256.
    add_point({32'sd0, 32'sd0});          // on a node
    add_point({32'sd0, 32'sd128});        // linear in x
    add_point({32'sd128, 32'sd0});        // linear in y
    add_point({32'sd77, 32'sd128});       // bilinear
    add_point({32'sd256, 32'sd256});      // last node
    add_point({32'sd0, 32'sd1});          // exactly the tolerance off a node
    add_point({32'sd255, 32'sd254});      // just inside the far edge in x; y exactly the tolerance off it
    add_point({-32'sd1000, -32'sd1000});  // outside, low corner
    add_point({32'sd300, 32'sd100});      // outside in y only
    add_point({32'h7FFF_FFFF, 32'h8000_0000});
    add_point({32'h8000_0000, 32'h7FFF_FFFF});
    add_point({32'hFFFF_FFFF, 32'hFFFF_FFFF});
    settle();

    // Zero tolerance: points on a node take the fallback; zero pitch acts as 1.
    set_grid(0, 0, 0, 256, 1, 8191, 0, 0);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    repeat (2) @(posedge clk_i);
    add_point({32'sd0, 32'sd0});
    add_point({32'sd256, 32'sd1});
    add_point({32'sd1000, 32'sd5});
    run_points(40);
    settle();

    stall_pct = 30;
    gap_max = 6;
    set_grid(-1280, 5000, 512, 300, 40, 17, 1, 20);
    run_points(90);
    settle();

    // Long receiver hold while points keep coming, so the input backs up.
    stall_pct = 0;
    gap_max = 0;
    hold_req = ~hold_req;
    run_points(90);
    settle();

    stall_pct = 50;
    gap_max = 3;
    set_grid($urandom, $urandom, $urandom_range(1, 2000), $urandom_range(1, 2000),
             $urandom_range(2, 64), $urandom_range(2, 64), 0, $urandom_range(0, 300));
    run_points(90);
    settle();

    stall_pct = 10;
    gap_max = 10;
    set_grid(32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 4096, 4096, 1, 65535);
    run_points(60);
    settle();

    set_grid(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2, 3, 0, 65535);
    run_points(60);
    settle();

    stall_pct = 0;
    gap_max = 0;
    set_grid(0, 0, 1, 3, 4096, 4096, 0, 1);
    run_points(60);
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      stall_pct = $urandom_range(0, 60);
      gap_max = $urandom_range(0, 8);
      set_grid($urandom, $urandom, $urandom_range(0, 100000), $urandom_range(0, 100000),
               $urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 1),
               $urandom_range(0, 4000));
      run_points(70);
      settle();
    end

    if (errors == 0)
      $display("** regular_grid_bilinear_weights_core: PASSED **");
    else
      $display("** regular_grid_bilinear_weights_core: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rgbw_pkg.sv
rtl/rgbw_axis.sv
rtl/regular_grid_bilinear_weights_core.sv
rtl/rgbw_checker.sv
bench/testbench.sv
